// ===== src/assert_macros.svh =====
// assertion helpers included by the dictionary rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, checked only outside reset
`define KDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must hold at every edge outside reset
`define KDL_ASSERT_ALWAYS(lbl, cond, msg) \
  `KDL_ASSERT(lbl, 1'b1 |-> (cond), msg)

`endif

// ===== src/kdl_pkg.sv =====
// ----------------------------------------------------------------------------
// kdl_pkg
// Shared constants, operation codes and text compare helpers of the keyword
// dictionary.
// ----------------------------------------------------------------------------
package kdl_pkg;

  localparam int DEPTH_DEF    = 64;
  localparam int WORD_LEN_DEF = 32;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SORT  = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  localparam logic ANS_LOOKUP = 1'b0;
  localparam logic ANS_SORT   = 1'b1;

  // outcome of comparing one 8-byte word of two texts
  typedef struct packed {
    logic decided;  // a difference or the terminator was found
    logic ne;       // texts differ
    logic gt;       // first text is greater
  } cmp_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  // byte 0 is the earliest character of the word
  function automatic cmp_t word_cmp(input logic [63:0] x, input logic [63:0] y);
    cmp_t       r;
    logic [7:0] fx;
    logic [7:0] fy;
    r = '0;
    for (int j = 0; j < 8; j++) begin
      if (!r.decided) begin
        fx = fold(x[8*j +: 8]);
        fy = fold(y[8*j +: 8]);
        if (fx != fy) begin
          r.decided = 1'b1;
          r.ne      = 1'b1;
          r.gt      = (fx > fy);
        end else if (fx == 8'd0) begin
          r.decided = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== src/kdl_ram.sv =====
// ----------------------------------------------------------------------------
// kdl_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module kdl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/keyword_dictionary_sort_and_lookup.sv =====
// ----------------------------------------------------------------------------
// keyword_dictionary_sort_and_lookup
// Case-insensitive word table with load, group-ordered sort, lookup and clear.
// ----------------------------------------------------------------------------
// Sequencing: a load or clear transaction is done in S_IDLE; a load that places
// its character in the last byte of an 8-byte memory word also passes S_LD_ZERO
// to zero the next word. Texts live in a RAM of 8-byte words with one read port
// and registered read data, and every compare step reads one word, so a lookup
// reads and then compares each text word it examines. The sort replays an
// exchange sort that restarts its inner scan after each swap: each pair reads
// the group numbers, then the text words on equal groups; a swap exchanges the
// entries word by word, and each outer step loads the cached entry and writes it
// back word by word. Only one transaction is worked on at a time; a result
// waits in an output register while the next transaction may be taken.
module keyword_dictionary_sort_and_lookup #(
  parameter int DEPTH    = kdl_pkg::DEPTH_DEF,
  parameter int WORD_LEN = kdl_pkg::WORD_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [7:0]         character_i,
  input  logic               is_last_i,
  input  logic signed [15:0] group_number_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               answer_kind_o,
  output logic               found_o,
  output logic [5:0]         entry_index_o,
  output logic [6:0]         entry_total_o
);

  import kdl_pkg::*;

  `include "assert_macros.svh"

  localparam int W  = (WORD_LEN + 7) / 8;
  localparam int WB = (W > 1) ? $clog2(W) : 1;
  localparam int WS = 1 << WB;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = $clog2(WORD_LEN);
  localparam int AW = IW + WB;
  localparam logic [WB-1:0] KLAST   = WB'(W - 1);
  localparam logic [PW-1:0] POS_MAX = PW'(WORD_LEN - 1);
  localparam logic [CW-1:0] FULL    = CW'(DEPTH);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_LD_ZERO = 14'b00000000000010,
    S_LK_RD   = 14'b00000000000100,
    S_LK_CMP  = 14'b00000000001000,
    S_SO_ARD  = 14'b00000000010000,
    S_SO_ACAP = 14'b00000000100000,
    S_SO_GRD  = 14'b00000001000000,
    S_SO_GCMP = 14'b00000010000000,
    S_SO_WRD  = 14'b00000100000000,
    S_SO_WCMP = 14'b00001000000000,
    S_SO_XRD  = 14'b00010000000000,
    S_SO_XWR  = 14'b00100000000000,
    S_SO_WB   = 14'b01000000000000,
    S_DONE    = 14'b10000000000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] qlen_q, qlen_d;
  logic [CW-1:0] a_q, a_d;
  logic [CW-1:0] b_q, b_d;
  logic [WB-1:0] k_q, k_d;
  logic          out_valid_q, out_valid_d;

  logic [63:0]   ld_buf_q, ld_buf_d;
  logic [AW-1:0] zaddr_q, zaddr_d;
  logic [63:0]   qry_q [WS];
  logic [63:0]   qry_d [WS];
  logic [63:0]   cache_q [WS];
  logic [63:0]   cache_d [WS];
  logic [15:0]   cache_grp_q, cache_grp_d;
  logic          res_kind_q, res_kind_d;
  logic          res_found_q, res_found_d;
  logic [IW-1:0] res_idx_q, res_idx_d;
  logic          out_kind_q, out_kind_d;
  logic          out_found_q, out_found_d;
  logic [5:0]    out_idx_q, out_idx_d;
  logic [6:0]    out_total_q, out_total_d;

  logic          wrd_we;
  logic [AW-1:0] wrd_waddr;
  logic [63:0]   wrd_wdata;
  logic [AW-1:0] wrd_raddr;
  logic [63:0]   wrd_rdata;
  logic          grp_we;
  logic [IW-1:0] grp_waddr;
  logic [15:0]   grp_wdata;
  logic [IW-1:0] grp_raddr;
  logic [15:0]   grp_rdata;

  logic          accept;
  op_e           op;
  logic          full;
  logic [5:0]    ld_sh;
  logic [63:0]   ld_mask;
  logic [63:0]   ld_new;
  logic [WB-1:0] ld_k;
  logic [5:0]    q_sh;
  logic [63:0]   q_mask;
  logic [63:0]   q_new;
  logic [WB-1:0] q_k;
  cmp_t          lk_cmp;
  cmp_t          so_cmp;
  logic          out_free;
  logic          next_b;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign op       = op_e'(operation_i);
  assign full     = (count_q >= FULL);
  assign out_free = !out_valid_q || !out_stall_i;

  // new word image: earlier bytes kept, the character placed, later bytes zero
  assign ld_sh   = {pos_q[2:0], 3'b000};
  assign ld_mask = (64'd1 << ld_sh) - 64'd1;
  assign ld_new  = (ld_buf_q & ld_mask) | ({56'd0, character_i} << ld_sh);
  assign ld_k    = WB'(pos_q >> 3);

  assign q_sh   = {qlen_q[2:0], 3'b000};
  assign q_mask = (64'd1 << q_sh) - 64'd1;
  assign q_k    = WB'(qlen_q >> 3);
  assign q_new  = (qry_q[q_k] & q_mask) | ({56'd0, character_i} << q_sh);

  assign lk_cmp = word_cmp(qry_q[k_q], wrd_rdata);
  assign so_cmp = word_cmp(cache_q[k_q], wrd_rdata);

  kdl_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH * WS)
  ) u_word_ram (
    .clk_i  (clk_i),
    .we_i   (wrd_we),
    .waddr_i(wrd_waddr),
    .wdata_i(wrd_wdata),
    .raddr_i(wrd_raddr),
    .rdata_o(wrd_rdata)
  );

  kdl_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_group_ram (
    .clk_i  (clk_i),
    .we_i   (grp_we),
    .waddr_i(grp_waddr),
    .wdata_i(grp_wdata),
    .raddr_i(grp_raddr),
    .rdata_o(grp_rdata)
  );

  // memory ports
  always_comb begin
    wrd_we    = 1'b0;
    wrd_waddr = '0;
    wrd_wdata = '0;
    wrd_raddr = {b_q[IW-1:0], k_q};
    grp_we    = 1'b0;
    grp_waddr = '0;
    grp_wdata = '0;
    grp_raddr = b_q[IW-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept && op == OP_LOAD && !full) begin
          wrd_we    = (pos_q < POS_MAX);
          wrd_waddr = {count_q[IW-1:0], ld_k};
          wrd_wdata = ld_new;
          grp_we    = is_last_i;
          grp_waddr = count_q[IW-1:0];
          grp_wdata = group_number_i;
        end
      end
      S_LD_ZERO: begin
        wrd_we    = 1'b1;
        wrd_waddr = zaddr_q;
      end
      S_SO_ARD: begin
        wrd_raddr = {a_q[IW-1:0], k_q};
        grp_raddr = a_q[IW-1:0];
      end
      S_SO_XWR: begin
        wrd_we    = 1'b1;
        wrd_waddr = {b_q[IW-1:0], k_q};
        wrd_wdata = cache_q[k_q];
        grp_we    = (k_q == '0);
        grp_waddr = b_q[IW-1:0];
        grp_wdata = cache_grp_q;
      end
      S_SO_WB: begin
        wrd_we    = 1'b1;
        wrd_waddr = {a_q[IW-1:0], k_q};
        wrd_wdata = cache_q[k_q];
        grp_we    = (k_q == '0);
        grp_waddr = a_q[IW-1:0];
        grp_wdata = cache_grp_q;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    qlen_d      = qlen_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    ld_buf_d    = ld_buf_q;
    zaddr_d     = zaddr_q;
    qry_d       = qry_q;
    cache_d     = cache_q;
    cache_grp_d = cache_grp_q;
    res_kind_d  = res_kind_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;
    out_total_d = out_total_q;
    next_b      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_LOAD: begin
              if (!full) begin
                if (pos_q < POS_MAX) begin
                  ld_buf_d = ld_new;
                  pos_d    = pos_q + PW'(1);
                  if (pos_q[2:0] == 3'd7) begin
                    // terminator spills into the next memory word
                    zaddr_d = {count_q[IW-1:0], WB'(ld_k + WB'(1))};
                    state_d = S_LD_ZERO;
                  end
                end
                if (is_last_i) begin
                  count_d = count_q + CW'(1);
                  pos_d   = '0;
                end
              end
            end
            OP_SORT: begin
              res_kind_d  = ANS_SORT;
              res_found_d = 1'b0;
              res_idx_d   = '0;
              a_d         = '0;
              k_d         = '0;
              state_d     = (count_q < CW'(2)) ? S_DONE : S_SO_ARD;
            end
            OP_QUERY: begin
              if (qlen_q < POS_MAX) begin
                qry_d[q_k] = q_new;
                if (qlen_q[2:0] == 3'd7) begin
                  qry_d[WB'(q_k + WB'(1))] = '0;
                end
                qlen_d = qlen_q + PW'(1);
              end
              if (is_last_i) begin
                qlen_d      = '0;
                res_kind_d  = ANS_LOOKUP;
                res_found_d = 1'b0;
                res_idx_d   = '0;
                b_d         = '0;
                k_d         = '0;
                state_d     = (count_q == '0) ? S_DONE : S_LK_RD;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              pos_d   = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_LD_ZERO: begin
        state_d = S_IDLE;
      end

      S_LK_RD: begin
        state_d = S_LK_CMP;
      end

      S_LK_CMP: begin
        if ((lk_cmp.decided && !lk_cmp.ne) || (!lk_cmp.decided && k_q == KLAST)) begin
          res_found_d = 1'b1;
          res_idx_d   = b_q[IW-1:0];
          state_d     = S_DONE;
        end else if (lk_cmp.decided) begin
          k_d = '0;
          if (b_q + CW'(1) == count_q) begin
            state_d = S_DONE;
          end else begin
            b_d     = b_q + CW'(1);
            state_d = S_LK_RD;
          end
        end else begin
          k_d     = k_q + WB'(1);
          state_d = S_LK_RD;
        end
      end

      S_SO_ARD: begin
        state_d = S_SO_ACAP;
      end

      // entry a is held in the cache for the whole inner scan
      S_SO_ACAP: begin
        cache_d[k_q] = wrd_rdata;
        if (k_q == '0) begin
          cache_grp_d = grp_rdata;
        end
        if (k_q == KLAST) begin
          b_d     = a_q + CW'(1);
          k_d     = '0;
          state_d = S_SO_GRD;
        end else begin
          k_d     = k_q + WB'(1);
          state_d = S_SO_ARD;
        end
      end

      S_SO_GRD: begin
        state_d = S_SO_GCMP;
      end

      S_SO_GCMP: begin
        k_d = '0;
        if ($signed(cache_grp_q) > $signed(grp_rdata)) begin
          state_d = S_SO_XRD;
        end else if (cache_grp_q == grp_rdata) begin
          state_d = S_SO_WRD;
        end else begin
          next_b = 1'b1;
        end
      end

      S_SO_WRD: begin
        state_d = S_SO_WCMP;
      end

      S_SO_WCMP: begin
        if (so_cmp.decided && so_cmp.gt) begin
          k_d     = '0;
          state_d = S_SO_XRD;
        end else if (so_cmp.decided || k_q == KLAST) begin
          next_b = 1'b1;
        end else begin
          k_d     = k_q + WB'(1);
          state_d = S_SO_WRD;
        end
      end

      S_SO_XRD: begin
        state_d = S_SO_XWR;
      end

      // old a goes to b, old b becomes the cached a
      S_SO_XWR: begin
        cache_d[k_q] = wrd_rdata;
        if (k_q == '0) begin
          cache_grp_d = grp_rdata;
        end
        if (k_q == KLAST) begin
          b_d     = a_q + CW'(1);
          k_d     = '0;
          state_d = S_SO_GRD;
        end else begin
          k_d     = k_q + WB'(1);
          state_d = S_SO_XRD;
        end
      end

      S_SO_WB: begin
        if (k_q == KLAST) begin
          a_d = a_q + CW'(1);
          k_d = '0;
          if (a_q + CW'(2) == count_q) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SO_ARD;
          end
        end else begin
          k_d = k_q + WB'(1);
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = res_kind_q;
          out_found_d = res_found_q;
          out_idx_d   = 6'(res_idx_q);
          out_total_d = 7'(count_q);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // advance the inner scan, or write the cached entry back at its end
    if (next_b) begin
      if (b_q + CW'(1) == count_q) begin
        k_d     = '0;
        state_d = S_SO_WB;
      end else begin
        b_d     = b_q + CW'(1);
        state_d = S_SO_GRD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      qlen_q      <= '0;
      a_q         <= '0;
      b_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      qlen_q      <= qlen_d;
      a_q         <= a_d;
      b_q         <= b_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_buf_q    <= ld_buf_d;
    zaddr_q     <= zaddr_d;
    qry_q       <= qry_d;
    cache_q     <= cache_d;
    cache_grp_q <= cache_grp_d;
    res_kind_q  <= res_kind_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    out_kind_q  <= out_kind_d;
    out_found_q <= out_found_d;
    out_idx_q   <= out_idx_d;
    out_total_q <= out_total_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign answer_kind_o = out_kind_q;
  assign found_o       = out_found_q;
  assign entry_index_o = out_idx_q;
  assign entry_total_o = out_total_q;

  `KDL_ASSERT_ALWAYS(a_count_bound, count_q <= FULL, "entry count beyond table depth")
  `KDL_ASSERT_ALWAYS(a_pos_bound, pos_q <= POS_MAX && qlen_q <= POS_MAX,
                     "text position beyond word length")
  `KDL_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE),
              "result raised outside the done step")
  `KDL_ASSERT_ALWAYS(a_lookup_idx, !(state_q == S_LK_RD || state_q == S_LK_CMP) ||
                     b_q < count_q, "lookup scan past the last entry")
  `KDL_ASSERT_ALWAYS(a_sort_pair, !(state_q == S_SO_GRD || state_q == S_SO_GCMP ||
                     state_q == S_SO_WRD || state_q == S_SO_WCMP ||
                     state_q == S_SO_XRD || state_q == S_SO_XWR) ||
                     (b_q > a_q && b_q < count_q), "sort pair out of order or range")

endmodule

// ===== verif/tb_keyword_dictionary_sort_and_lookup.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyword_dictionary_sort_and_lookup
// Drives load, sort, query and clear transactions with random idle and stall
// on both channels. Each result is checked field by field against a local
// model of the dictionary, or against a typed value in the directed table.
// ----------------------------------------------------------------------------
module tb_keyword_dictionary_sort_and_lookup;
  import kdl_pkg::*;

  localparam int NENT      = 64;
  localparam int WLEN      = 32;
  localparam int IDLE_PCT  = 38;
  localparam int WDOG_MAX  = 400000;
  localparam int N_RANDOM  = 1000;

  typedef logic [7:0] text_t [WLEN];

  typedef struct packed {
    logic       kind;
    logic       hit;
    logic [5:0] idx;
    logic [6:0] total;
  } answer_t;

  typedef struct {
    op_e                op;
    logic [7:0]         ch;
    logic               last;
    logic signed [15:0] grp;
    bit                 typed;
    answer_t            ans;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         operation_i;
  logic [7:0]         character_i;
  logic               is_last_i;
  logic signed [15:0] group_number_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               answer_kind_o;
  logic               found_o;
  logic [5:0]         entry_index_o;
  logic [6:0]         entry_total_o;

  keyword_dictionary_sort_and_lookup dut (.*);

  // dictionary model state
  text_t              dict_text [NENT];
  logic signed [15:0] dict_grp [NENT];
  int                 dict_cnt;
  int                 dict_lpos;
  text_t              qry_text;
  int                 qry_len;

  answer_t pending_answers [$];
  int      n_errors;
  bit      quiet;
  int      wdog;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [7:0] fold_ch(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic int text_order(input text_t x, input text_t y);
    logic [7:0] a;
    logic [7:0] b;
    for (int i = 0; i < WLEN; i++) begin
      a = fold_ch(x[i]);
      b = fold_ch(y[i]);
      if (a != b) return (a < b) ? -1 : 1;
      if (a == 8'd0) return 0;
    end
    return 0;
  endfunction

  // exchange sort that restarts its inner scan after each swap
  task automatic sort_dict();
    text_t              t;
    logic signed [15:0] g;
    for (int a = 0; a < dict_cnt; a++) begin
      for (int b = a + 1; b < dict_cnt; b++) begin
        if (dict_grp[a] > dict_grp[b] ||
            (dict_grp[a] == dict_grp[b] && text_order(dict_text[a], dict_text[b]) > 0)) begin
          g = dict_grp[a]; dict_grp[a] = dict_grp[b]; dict_grp[b] = g;
          t = dict_text[a]; dict_text[a] = dict_text[b]; dict_text[b] = t;
          b = a;
        end
      end
    end
  endtask

  // advances the model by one transaction, returns 1 when it yields an answer
  task automatic dict_step(input op_e op, input logic [7:0] ch, input logic last,
                           input logic signed [15:0] grp, output bit has,
                           output answer_t ans);
    int hit_at;
    has = 0;
    ans = '0;
    case (op)
      OP_LOAD: begin
        if (dict_cnt < NENT) begin
          if (dict_lpos < WLEN - 1) begin
            dict_text[dict_cnt][dict_lpos] = ch;
            dict_text[dict_cnt][dict_lpos+1] = 8'd0;
            dict_lpos++;
          end
          if (last) begin
            dict_grp[dict_cnt] = grp;
            dict_cnt++;
            dict_lpos = 0;
          end
        end
      end
      OP_SORT: begin
        sort_dict();
        has = 1;
        ans.kind = ANS_SORT;
        ans.total = dict_cnt[6:0];
      end
      OP_QUERY: begin
        if (qry_len < WLEN - 1) begin
          qry_text[qry_len] = ch;
          qry_text[qry_len+1] = 8'd0;
          qry_len++;
        end
        if (last) begin
          hit_at = -1;
          for (int i = 0; i < dict_cnt && hit_at < 0; i++)
            if (text_order(qry_text, dict_text[i]) == 0) hit_at = i;
          qry_len = 0;
          foreach (qry_text[i]) qry_text[i] = 8'd0;
          has = 1;
          ans.kind = ANS_LOOKUP;
          ans.hit = (hit_at >= 0);
          ans.idx = (hit_at >= 0) ? hit_at[5:0] : 6'd0;
          ans.total = dict_cnt[6:0];
        end
      end
      default: begin
        dict_cnt = 0;
        dict_lpos = 0;
      end
    endcase
  endtask

  task automatic send(input op_e op, input logic [7:0] ch, input logic last,
                      input logic signed [15:0] grp);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    character_i    <= ch;
    is_last_i      <= last;
    group_number_i <= grp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // predicts, queues the answer and drives one transaction
  task automatic issue(input op_e op, input logic [7:0] ch, input logic last,
                       input logic signed [15:0] grp);
    bit      has;
    answer_t ans;
    dict_step(op, ch, last, grp, has, ans);
    if (has) pending_answers.push_back(ans);
    send(op, ch, last, grp);
  endtask

  task automatic issue_word(input op_e op, input logic [7:0] w [$],
                            input logic signed [15:0] grp);
    foreach (w[i]) issue(op, w[i], i == w.size() - 1, grp);
  endtask

  // output side: stall, check and watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      wdog <= 0;
    end else begin
      out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("tb: failure");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_answers.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result kind=%0d", answer_kind_o);
        end else begin
          answer_t e;
          e = pending_answers.pop_front();
          if (e.kind !== answer_kind_o || e.hit !== found_o ||
              e.idx !== entry_index_o || e.total !== entry_total_o) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch exp kind=%0d found=%0d idx=%0d total=%0d got %0d %0d %0d %0d",
                       e.kind, e.hit, e.idx, e.total,
                       answer_kind_o, found_o, entry_index_o, entry_total_o);
          end
        end
      end
    end
  end

  row_t dir_tab [] = '{
    '{OP_SORT,  8'h00, 1'b1, 16'sd0,      1'b1, '{ANS_SORT,   1'b0, 6'd0, 7'd0}},
    '{OP_QUERY, "a",   1'b1, 16'sd0,      1'b1, '{ANS_LOOKUP, 1'b0, 6'd0, 7'd0}},
    '{OP_LOAD,  "A",   1'b0, 16'sd0,      1'b0, '0},
    '{OP_LOAD,  "b",   1'b1, 16'sd5,      1'b0, '0},
    '{OP_LOAD,  "a",   1'b0, 16'sd0,      1'b0, '0},
    '{OP_LOAD,  "B",   1'b1, -16'sd32768, 1'b0, '0},
    '{OP_LOAD,  "z",   1'b1, 16'sd32767,  1'b0, '0},
    '{OP_LOAD,  "c",   1'b0, 16'sd0,      1'b0, '0},
    '{OP_LOAD,  8'h00, 1'b0, 16'sd0,      1'b0, '0},
    '{OP_LOAD,  "d",   1'b1, 16'sd5,      1'b0, '0},
    '{OP_LOAD,  8'hff, 1'b1, -16'sd1,     1'b0, '0},
    '{OP_QUERY, "a",   1'b0, 16'sd0,      1'b0, '0},
    '{OP_QUERY, "B",   1'b1, 16'sd0,      1'b0, '0},
    '{OP_QUERY, "C",   1'b1, 16'sd0,      1'b0, '0},
    '{OP_QUERY, 8'hff, 1'b1, 16'sd0,      1'b0, '0},
    '{OP_QUERY, "Z",   1'b0, 16'sd0,      1'b0, '0},
    '{OP_SORT,  8'h00, 1'b1, 16'sd0,      1'b1, '{ANS_SORT,   1'b0, 6'd0, 7'd5}},
    '{OP_QUERY, "A",   1'b0, 16'sd0,      1'b0, '0},
    '{OP_CLEAR, 8'h00, 1'b0, 16'sd0,      1'b0, '0},
    '{OP_QUERY, "b",   1'b1, 16'sd0,      1'b1, '{ANS_LOOKUP, 1'b0, 6'd0, 7'd0}},
    '{OP_LOAD,  "x",   1'b0, 16'sd0,      1'b0, '0},
    '{OP_SORT,  8'h00, 1'b0, 16'sd0,      1'b0, '0},
    '{OP_LOAD,  "y",   1'b1, 16'sd3,      1'b0, '0},
    '{OP_QUERY, "X",   1'b0, 16'sd0,      1'b0, '0},
    '{OP_QUERY, "Y",   1'b1, 16'sd0,      1'b0, '0}
  };

  initial begin
    logic [7:0]         w [$];
    logic [7:0]         c;
    logic signed [15:0] g;
    bit                 has;
    answer_t            ans;
    int                 sent;
    int                 len;
    int                 pick;
    int                 r;
    logic [7:0]         loaded [$][$];

    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = OP_LOAD;
    character_i    = 8'h00;
    is_last_i      = 1'b0;
    group_number_i = '0;
    quiet          = 1'b0;
    n_errors       = 0;
    dict_cnt = 0; dict_lpos = 0; qry_len = 0;
    foreach (dict_text[i, j]) dict_text[i][j] = 8'd0;
    foreach (dict_grp[i]) dict_grp[i] = '0;
    foreach (qry_text[i]) qry_text[i] = 8'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) begin
      dict_step(dir_tab[k].op, dir_tab[k].ch, dir_tab[k].last, dir_tab[k].grp, has, ans);
      if (has) pending_answers.push_back(dir_tab[k].typed ? dir_tab[k].ans : ans);
      send(dir_tab[k].op, dir_tab[k].ch, dir_tab[k].last, dir_tab[k].grp);
    end

    // hold off until the directed answers have all drained
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);

    sent = 0;
    while (sent < N_RANDOM) begin
      quiet = (sent >= 300 && sent < 450);
      r = $urandom_range(99);
      if (sent >= 600 && sent < 610) begin
        // fill past capacity, then sort and probe the full table
        issue(OP_CLEAR, $urandom, $urandom, $urandom);
        loaded.delete();
        for (int n = 0; n < NENT + 3; n++) begin
          w.delete();
          len = $urandom_range(1, 3);
          repeat (len) w.push_back("a" + $urandom_range(0, 3));
          issue_word(OP_LOAD, w, $urandom);
          if (n < NENT) loaded.push_back(w);
          sent += len;
        end
        issue(OP_SORT, $urandom, $urandom, $urandom);
        repeat (4) begin
          issue_word(OP_QUERY, loaded[$urandom_range(0, NENT - 1)], $urandom);
          sent += 3;
        end
        issue(OP_CLEAR, $urandom, $urandom, $urandom);
        loaded.delete();
        sent += 3;
      end else if (r < 50) begin
        w.delete();
        len = ($urandom_range(99) < 5) ? $urandom_range(28, 40) : $urandom_range(1, 5);
        for (int n = 0; n < len; n++) begin
          pick = $urandom_range(99);
          if (pick < 3) c = 8'h00;
          else if (pick < 15) c = $urandom;
          else c = "a" + $urandom_range(0, 2) - (($urandom_range(1)) ? 8'd32 : 8'd0);
          w.push_back(c);
        end
        g = ($urandom_range(99) < 60) ? $urandom_range(0, 3) - 16'sd2 : $urandom;
        issue_word(OP_LOAD, w, g);
        loaded.push_back(w);
        sent += len;
      end else if (r < 78) begin
        w.delete();
        if (loaded.size() != 0 && $urandom_range(99) < 65) begin
          w = loaded[$urandom_range(0, loaded.size() - 1)];
          foreach (w[i])
            if ($urandom_range(1) && fold_ch(w[i]) >= "a" && fold_ch(w[i]) <= "z")
              w[i] = w[i] ^ 8'h20;
        end else begin
          len = $urandom_range(1, 4);
          repeat (len) w.push_back(($urandom_range(9) == 0) ? $urandom : "a" + $urandom_range(0, 2));
        end
        issue_word(OP_QUERY, w, $urandom);
        sent += w.size();
      end else if (r < 86) begin
        if (dict_cnt <= 24) issue(OP_SORT, $urandom, $urandom, $urandom);
        else issue(OP_CLEAR, $urandom, $urandom, $urandom);
        sent++;
      end else if (r < 92 || dict_cnt > 20) begin
        issue(OP_CLEAR, $urandom, $urandom, $urandom);
        if (dict_lpos == 0) loaded.delete();
        sent++;
      end else begin
        // stray single characters break words in progress
        issue(op_e'($urandom_range(0, 2) & 2'b10), $urandom, 1'b0, $urandom);
        sent++;
      end
      if (dict_cnt == 0 && dict_lpos == 0) loaded.delete();
    end

    in_valid_i <= 1'b0;
    quiet = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (pending_answers.size() != 0) n_errors++;
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/kdl_pkg.sv
src/kdl_ram.sv
src/keyword_dictionary_sort_and_lookup.sv
verif/tb_keyword_dictionary_sort_and_lookup.sv
